### rtl/wtq_pkg.sv
package wtq_pkg;

   localparam int CALIB_COUNT_DEF = 50;
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int CONTACT_W = 12;
   localparam int STUCK_W   = 16;
   localparam int GAIN_W    = 16;
   localparam int SIGN_W    = 2;
   localparam int TIME_W    = 32;
   localparam int TURN_W    = 2;
   localparam int ADDR_W    = 5;
   localparam int DATA_W    = 32;
   localparam int INDEX_W   = 3;

   localparam logic [INDEX_W-1:0] REG_TOUCH_HI   = 3'd0;
   localparam logic [INDEX_W-1:0] REG_TOUCH_LO   = 3'd1;
   localparam logic [INDEX_W-1:0] REG_HOLD_LIMIT = 3'd2;
   localparam logic [INDEX_W-1:0] REG_FRONT_SIGN = 3'd3;
   localparam logic [INDEX_W-1:0] REG_TRACK_GAIN = 3'd4;

   localparam logic [CONTACT_W-1:0] TOUCH_HI_RST   = 12'd150;
   localparam logic [CONTACT_W-1:0] TOUCH_LO_RST   = 12'd100;
   localparam logic [STUCK_W-1:0]   HOLD_LIMIT_RST = 16'd3000;
   localparam logic [SIGN_W-1:0]    FRONT_SIGN_RST = 2'b01;
   localparam logic [GAIN_W-1:0]    TRACK_GAIN_RST = 16'd655;

   // direction codes; both remaining codes mean falling
   localparam logic [SIGN_W-1:0] SIGN_EITHER = 2'b00;
   localparam logic [SIGN_W-1:0] SIGN_RISE   = 2'b01;

   localparam logic OP_CALIB = 1'b0;
   localparam logic OP_RUN   = 1'b1;

   localparam logic [TURN_W-1:0] TURN_NONE  = 2'd0;
   localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd1;
   localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd2;
   localparam logic [TURN_W-1:0] TURN_FRONT = 2'd3;

   typedef struct packed {
      logic [CONTACT_W-1:0] touch_hi;
      logic [CONTACT_W-1:0] touch_lo;
      logic [STUCK_W-1:0]   hold_limit;
      logic [GAIN_W-1:0]    track_gain;
   } cfg_type;

   typedef struct packed {
      logic calib;
      logic last;
   } lane_ctl_type;

   typedef struct packed {
      logic onset;
      logic held;
   } lane_stat_type;

endpackage

### rtl/wtq_if.sv
interface wtq_req_if import wtq_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [SAMPLE_BITS-1:0] sample_right;
   logic [SAMPLE_BITS-1:0] sample_front;
   logic [SAMPLE_BITS-1:0] sample_left;
   logic [TIME_W-1:0]      now_ms;
   logic                   turn_idle;

   modport source (
      output valid, op, sample_right, sample_front, sample_left, now_ms, turn_idle,
      input  ready
   );
   modport sink (
      input  valid, op, sample_right, sample_front, sample_left, now_ms, turn_idle,
      output ready
   );
endinterface

interface wtq_rsp_if import wtq_pkg::*;;
   logic              valid;
   logic              ready;
   logic              onset_right;
   logic              onset_front;
   logic              onset_left;
   logic              held_right;
   logic              held_front;
   logic              held_left;
   logic [TURN_W-1:0] turn_request;
   logic              calib_done;

   modport source (
      output valid, onset_right, onset_front, onset_left, held_right, held_front,
             held_left, turn_request, calib_done,
      input  ready
   );
   modport sink (
      input  valid, onset_right, onset_front, onset_left, held_right, held_front,
             held_left, turn_request, calib_done,
      output ready
   );
endinterface

### rtl/wtq_lane.sv
module wtq_lane import wtq_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int CALIB_COUNT = CALIB_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  lane_ctl_type           ctl,
   input  cfg_type                cfg,
   input  logic [SIGN_W-1:0]      sign_code,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [TIME_W-1:0]      now_ms,
   output lane_stat_type          stat
);

   localparam int REST_W  = SAMPLE_BITS + FRAC_BITS;
   localparam int SUM_W   = SAMPLE_BITS + $clog2(CALIB_COUNT);
   localparam int DIV_K   = SUM_W + $clog2(CALIB_COUNT);
   localparam int RECIP_W = DIV_K + 1;
   localparam int DEV_W   = (SAMPLE_BITS + 2 > CONTACT_W + 1) ? SAMPLE_BITS + 2 : CONTACT_W + 1;
   localparam int PROD_W  = REST_W + GAIN_W;
   localparam int QPROD_W = SUM_W + RECIP_W;
   // ceil(2^k / count): exact floor division for every sum that fits SUM_W
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_K) + 64'(CALIB_COUNT) - 64'd1) / 64'(CALIB_COUNT));

   logic [REST_W-1:0]        rest_ff, rest_in;
   logic                     away_ff, away_in;
   logic [TIME_W-1:0]        since_ff, since_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;

   logic [REST_W-1:0]        sample_fx, diff, step, tracked;
   logic [PROD_W-1:0]        prod;
   logic                     rising;
   logic [SUM_W-1:0]         sum_next;
   logic [QPROD_W-1:0]       quot_prod;
   logic [SAMPLE_BITS-1:0]   mean;
   logic signed [DEV_W-1:0]  delta, dev, on_thr, off_thr;
   logic [TIME_W-1:0]        held_ms;
   logic                     onset;

   // rest tracker, truncated toward zero
   always_comb begin
      sample_fx = {sample, {FRAC_BITS{1'b0}}};
      rising    = sample_fx >= rest_ff;
      diff      = rising ? sample_fx - rest_ff : rest_ff - sample_fx;
      prod      = {{GAIN_W{1'b0}}, diff} * {{REST_W{1'b0}}, cfg.track_gain};
      step      = prod[PROD_W-1:GAIN_W];
      tracked   = rising ? rest_ff + step : rest_ff - step;
   end

   always_comb begin
      delta = $signed({{(DEV_W-SAMPLE_BITS){1'b0}}, sample})
            - $signed({{(DEV_W-SAMPLE_BITS){1'b0}}, rest_ff[REST_W-1:FRAC_BITS]});
      case (sign_code)
         SIGN_EITHER: dev = (delta < 0) ? -delta : delta;
         SIGN_RISE:   dev = delta;
         default:     dev = -delta;
      endcase
      on_thr  = $signed({{(DEV_W-CONTACT_W){1'b0}}, cfg.touch_hi});
      off_thr = $signed({{(DEV_W-CONTACT_W){1'b0}}, cfg.touch_lo});
      held_ms = now_ms - since_ff;
   end

   // calibration average by reciprocal multiply
   always_comb begin
      sum_next  = sum_ff + SUM_W'(sample);
      quot_prod = {{RECIP_W{1'b0}}, sum_next} * {{SUM_W{1'b0}}, RECIP};
      mean      = quot_prod[DIV_K +: SAMPLE_BITS];
   end

   always_comb begin
      rest_in  = rest_ff;
      away_in  = away_ff;
      since_in = since_ff;
      sum_in   = sum_ff;
      onset    = 1'b0;
      if (accept) begin
         if (ctl.calib) begin
            if (ctl.last) begin
               rest_in = {mean, {FRAC_BITS{1'b0}}};
               sum_in  = '0;
               away_in = 1'b0;
            end else begin
               sum_in = sum_next;
            end
         end else if (!away_ff) begin
            rest_in = tracked;
            if (dev > on_thr) begin
               away_in  = 1'b1;
               since_in = now_ms;
               onset    = 1'b1;
            end
         end else if (dev < off_thr) begin
            away_in = 1'b0;
         end else if (held_ms > {{(TIME_W-STUCK_W){1'b0}}, cfg.hold_limit}) begin
            rest_in = sample_fx;
            away_in = 1'b0;
         end
      end
      stat.onset = onset;
      stat.held  = away_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_ff <= '0;
         away_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         rest_ff <= rest_in;
         away_ff <= away_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      since_ff <= since_in;
   end

endmodule

### rtl/wtq_merge.sv
module wtq_merge import wtq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  lane_stat_type stat_right,
   input  lane_stat_type stat_front,
   input  lane_stat_type stat_left,
   input  logic          turn_idle,
   input  logic          done,
   output logic          slot_free,
   wtq_rsp_if.source     rsp
);

   logic              valid_ff, valid_in;
   logic [2:0]        onset_ff, onset_in;
   logic [2:0]        held_ff, held_in;
   logic [TURN_W-1:0] turn_ff, turn_in;
   logic              done_ff, done_in;

   always_comb begin
      slot_free = !valid_ff || rsp.ready;
      valid_in  = accept || (valid_ff && !rsp.ready);
      onset_in  = onset_ff;
      held_in   = held_ff;
      turn_in   = turn_ff;
      done_in   = done_ff;
      if (accept) begin
         onset_in = {stat_left.onset, stat_front.onset, stat_right.onset};
         held_in  = {stat_left.held, stat_front.held, stat_right.held};
         done_in  = done;
         turn_in  = TURN_NONE;
         if (turn_idle) begin
            if (stat_right.onset) begin
               turn_in = TURN_RIGHT;
            end else if (stat_left.onset) begin
               turn_in = TURN_LEFT;
            end else if (stat_front.onset) begin
               turn_in = TURN_FRONT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      onset_ff <= onset_in;
      held_ff  <= held_in;
      turn_ff  <= turn_in;
      done_ff  <= done_in;
   end

   assign rsp.valid        = valid_ff;
   assign rsp.onset_right  = onset_ff[0];
   assign rsp.onset_front  = onset_ff[1];
   assign rsp.onset_left   = onset_ff[2];
   assign rsp.held_right   = held_ff[0];
   assign rsp.held_front   = held_ff[1];
   assign rsp.held_left    = held_ff[2];
   assign rsp.turn_request = turn_ff;
   assign rsp.calib_done   = done_ff;

endmodule

### rtl/whisker_touch_qualifier_unit.sv
// latency: a result beat is valid the cycle after its request beat is accepted
// throughput: one request beat per cycle unless an unaccepted result beat waits on rsp.ready,
//   set by the per-lane rest update (tracker multiply and add), which is combinational
// reset: synchronous, clears rest levels, away flags, calibration sums and count,
//   loads register defaults; no clearing pass, ready in the first cycle after reset
module whisker_touch_qualifier_unit import wtq_pkg::*; #(
   parameter int CALIB_COUNT = CALIB_COUNT_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   wtq_req_if.sink           req,
   wtq_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   localparam int CNT_W = $clog2(CALIB_COUNT + 1);

   cfg_type            cfg_ff, cfg_in;
   logic [SIGN_W-1:0]  front_sign_ff, front_sign_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [INDEX_W-1:0] reg_index;
   logic               csr_write;
   logic               accept;
   logic               slot_free;
   lane_ctl_type       ctl;
   lane_stat_type      stat_right, stat_front, stat_left;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      cfg_in        = cfg_ff;
      front_sign_in = front_sign_ff;
      if (csr_write) begin
         unique case (reg_index)
            REG_TOUCH_HI:   cfg_in.touch_hi   = pwdata[CONTACT_W-1:0];
            REG_TOUCH_LO:   cfg_in.touch_lo   = pwdata[CONTACT_W-1:0];
            REG_HOLD_LIMIT: cfg_in.hold_limit = pwdata[STUCK_W-1:0];
            REG_FRONT_SIGN: front_sign_in     = pwdata[SIGN_W-1:0];
            REG_TRACK_GAIN: cfg_in.track_gain = pwdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_TOUCH_HI:   prdata = {{(DATA_W-CONTACT_W){1'b0}}, cfg_ff.touch_hi};
         REG_TOUCH_LO:   prdata = {{(DATA_W-CONTACT_W){1'b0}}, cfg_ff.touch_lo};
         REG_HOLD_LIMIT: prdata = {{(DATA_W-STUCK_W){1'b0}}, cfg_ff.hold_limit};
         REG_FRONT_SIGN: prdata = {{(DATA_W-SIGN_W){1'b0}}, front_sign_ff};
         REG_TRACK_GAIN: prdata = {{(DATA_W-GAIN_W){1'b0}}, cfg_ff.track_gain};
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.touch_hi   <= TOUCH_HI_RST;
         cfg_ff.touch_lo   <= TOUCH_LO_RST;
         cfg_ff.hold_limit <= HOLD_LIMIT_RST;
         cfg_ff.track_gain <= TRACK_GAIN_RST;
         front_sign_ff     <= FRONT_SIGN_RST;
      end else begin
         cfg_ff        <= cfg_in;
         front_sign_ff <= front_sign_in;
      end
   end

   assign req.ready = slot_free;
   assign accept    = req.valid && slot_free;

   always_comb begin
      ctl.calib = (req.op == OP_CALIB);
      ctl.last  = (count_ff == CNT_W'(CALIB_COUNT - 1));
      count_in  = count_ff;
      if (accept && ctl.calib) begin
         count_in = ctl.last ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   wtq_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .CALIB_COUNT (CALIB_COUNT)
   ) u_lane_right (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .sign_code (SIGN_EITHER),
      .sample    (req.sample_right),
      .now_ms    (req.now_ms),
      .stat      (stat_right)
   );

   wtq_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .CALIB_COUNT (CALIB_COUNT)
   ) u_lane_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .sign_code (front_sign_ff),
      .sample    (req.sample_front),
      .now_ms    (req.now_ms),
      .stat      (stat_front)
   );

   wtq_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS),
      .CALIB_COUNT (CALIB_COUNT)
   ) u_lane_left (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .sign_code (SIGN_EITHER),
      .sample    (req.sample_left),
      .now_ms    (req.now_ms),
      .stat      (stat_left)
   );

   wtq_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .stat_right (stat_right),
      .stat_front (stat_front),
      .stat_left  (stat_left),
      .turn_idle  (req.turn_idle),
      .done       (ctl.calib && ctl.last),
      .slot_free  (slot_free),
      .rsp        (rsp)
   );

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CALIB_COUNT - 1))
      else $error("calibration count past its limit");

   a_onset_held : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.onset_right || rsp.onset_front || rsp.onset_left) |->
         (!rsp.onset_right || rsp.held_right) && (!rsp.onset_front || rsp.held_front)
         && (!rsp.onset_left || rsp.held_left))
      else $error("onset beat without the channel held");

   a_done_clears : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.calib_done |->
         !rsp.held_right && !rsp.held_front && !rsp.held_left
         && rsp.turn_request == TURN_NONE)
      else $error("calibration load beat with held channel or turn");

   a_turn_source : assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.turn_request == TURN_LEFT |-> rsp.onset_left && !rsp.onset_right)
      else $error("left turn without left onset or with right onset");

endmodule
